[rtl/nearest_palette_color_match_macros.svh]
// ----------------------------------------------------------------------------
// nearest palette colour match: assertion macros
// Concurrent check helpers used by the top-level rtl file.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MATCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MATCH_MACROS_SVH

// same-cycle implication, held off during reset
`define NPCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcm check failed");

// next-cycle implication, held off during reset
`define NPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("npcm check failed");

`endif

[rtl/npcm_pkg.sv]
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared constants, types and the palette rom for the colour matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

    localparam int unsigned PALETTE_SIZE    = 16;
    localparam int unsigned LIST_LEN        = 16;
    localparam int unsigned LIST_LEVELS     = $clog2(LIST_LEN);
    localparam int unsigned POS_WIDTH       = 4;
    localparam int unsigned INDEX_WIDTH     = 4;
    localparam int unsigned COUNT_WIDTH     = 5;
    localparam int unsigned CHAN_WIDTH      = 8;
    localparam int unsigned PIXEL_WIDTH     = 24;
    localparam int unsigned SUM_WIDTH       = 10;
    localparam int unsigned PROD_WIDTH      = 19;
    localparam int unsigned DIST_WIDTH      = 9;
    localparam int unsigned THIRD_SHIFT     = 11;
    localparam int unsigned CFG_INDEX_WIDTH = 8;
    localparam int unsigned CFG_DATA_WIDTH  = 64;
    localparam int unsigned OUT_TDATA_WIDTH = 8;

    // x * 683 >> 11 equals x / 3 for x up to 765
    localparam logic [SUM_WIDTH-1:0] RECIP_THIRD = 10'd683;

    // larger than any real distance, so an unsearched position never wins
    localparam logic [DIST_WIDTH-1:0] DIST_NONE = 9'd256;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUBSET_INDICES = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUBSET_COUNT   = 8'd1;

    localparam logic [CFG_DATA_WIDTH-1:0] SUBSET_INDICES_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [COUNT_WIDTH-1:0]    SUBSET_COUNT_RESET   = 5'd16;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] score;
        logic [POS_WIDTH-1:0]  pos;
    } t_cand;

    // palette colours as 0xRRGGBB
    function automatic logic [PIXEL_WIDTH-1:0] rom_color(input logic [INDEX_WIDTH-1:0] idx);
        logic [PIXEL_WIDTH-1:0] col;
        case (idx)
            4'd0:    col = 24'h000000;
            4'd1:    col = 24'hffffff;
            4'd2:    col = 24'h894036;
            4'd3:    col = 24'h7abfc7;
            4'd4:    col = 24'h8a46ae;
            4'd5:    col = 24'h68a941;
            4'd6:    col = 24'h3e31a2;
            4'd7:    col = 24'hd0dc71;
            4'd8:    col = 24'h905f25;
            4'd9:    col = 24'h5c4700;
            4'd10:   col = 24'hbb776d;
            4'd11:   col = 24'h555555;
            4'd12:   col = 24'h808080;
            4'd13:   col = 24'hacea88;
            4'd14:   col = 24'h7c70da;
            4'd15:   col = 24'hababab;
            default: col = 24'h000000;
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

[rtl/npcm_lane.sv]
// ----------------------------------------------------------------------------
// npcm_lane
// Distance from one pixel to one palette colour: sum of channel differences
// divided by three, or a no-match value when the position is not searched.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_lane (
    input  wire logic [npcm_pkg::PIXEL_WIDTH-1:0] i_pixel,
    input  wire logic [npcm_pkg::INDEX_WIDTH-1:0] i_pal_index,
    input  wire logic                             i_active,
    output logic      [npcm_pkg::DIST_WIDTH-1:0]  o_dist
);

    logic [npcm_pkg::INDEX_WIDTH-1:0] idx;
    logic [npcm_pkg::PIXEL_WIDTH-1:0] col;
    logic [npcm_pkg::CHAN_WIDTH-1:0]  ad_r;
    logic [npcm_pkg::CHAN_WIDTH-1:0]  ad_g;
    logic [npcm_pkg::CHAN_WIDTH-1:0]  ad_b;
    logic [npcm_pkg::SUM_WIDTH-1:0]   sum;
    logic [npcm_pkg::PROD_WIDTH-1:0]  prod;

    function automatic logic [npcm_pkg::CHAN_WIDTH-1:0] abs_diff(
        input logic [npcm_pkg::CHAN_WIDTH-1:0] a,
        input logic [npcm_pkg::CHAN_WIDTH-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        // indices past the palette saturate to its last entry
        if ({1'b0, i_pal_index} >= (npcm_pkg::INDEX_WIDTH+1)'(npcm_pkg::PALETTE_SIZE)) begin
            idx = npcm_pkg::INDEX_WIDTH'(npcm_pkg::PALETTE_SIZE - 1);
        end else begin
            idx = i_pal_index;
        end
        col  = npcm_pkg::rom_color(idx);
        // rom red is compared with the pixel's low byte, rom blue with its high byte
        ad_r = abs_diff(col[23:16], i_pixel[7:0]);
        ad_g = abs_diff(col[15:8],  i_pixel[15:8]);
        ad_b = abs_diff(col[7:0],   i_pixel[23:16]);
        sum  = npcm_pkg::SUM_WIDTH'(ad_r) + npcm_pkg::SUM_WIDTH'(ad_g)
             + npcm_pkg::SUM_WIDTH'(ad_b);
        prod = npcm_pkg::PROD_WIDTH'(sum) * npcm_pkg::PROD_WIDTH'(npcm_pkg::RECIP_THIRD);
        if (i_active) begin
            o_dist = {1'b0, prod[npcm_pkg::THIRD_SHIFT +: npcm_pkg::CHAN_WIDTH]};
        end else begin
            o_dist = npcm_pkg::DIST_NONE;
        end
    end

endmodule

`default_nettype wire

[rtl/npcm_argmin.sv]
// ----------------------------------------------------------------------------
// npcm_argmin
// Compare tree over the list positions; the lower position wins a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_argmin (
    input  wire npcm_pkg::t_cand [npcm_pkg::LIST_LEN-1:0] i_cands,
    output npcm_pkg::t_cand                               o_best
);

    npcm_pkg::t_cand lvl [0:npcm_pkg::LIST_LEVELS][0:npcm_pkg::LIST_LEN-1];

    always_comb begin
        for (int l = 0; l <= npcm_pkg::LIST_LEVELS; l++) begin
            for (int i = 0; i < npcm_pkg::LIST_LEN; i++) begin
                lvl[l][i] = '0;
            end
        end
        for (int i = 0; i < npcm_pkg::LIST_LEN; i++) begin
            lvl[0][i] = i_cands[i];
        end
        for (int l = 0; l < npcm_pkg::LIST_LEVELS; l++) begin
            for (int i = 0; i < npcm_pkg::LIST_LEN / 2; i++) begin
                if (i < (npcm_pkg::LIST_LEN >> (l + 1))) begin
                    // right side replaces left only when strictly closer
                    if (lvl[l][2*i+1].score < lvl[l][2*i].score) begin
                        lvl[l+1][i] = lvl[l][2*i+1];
                    end else begin
                        lvl[l+1][i] = lvl[l][2*i];
                    end
                end
            end
        end
        o_best = lvl[npcm_pkg::LIST_LEVELS][0];
    end

endmodule

`default_nettype wire

[rtl/nearest_palette_color_match.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Nearest palette colour search over a configurable subset list.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// list position per pixel through an input register, a register holding the
// sixteen per-position distances, and the result register. With one distance
// lane per list position, a new pixel can enter before the last is through.
// The user must write registers 0 (subset indices) and 1 (subset count)
// through the cfg port only while no item is in flight; the block does not
// enforce this. The cfg port is always ready and other indices are ignored.
`default_nettype none

`include "nearest_palette_color_match_macros.svh"

module nearest_palette_color_match (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [npcm_pkg::PIXEL_WIDTH-1:0]      i_s_axis_tdata,  // pixel_color
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    output logic      [npcm_pkg::OUT_TDATA_WIDTH-1:0]  o_m_axis_tdata,  // list_position, zero pad
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [npcm_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [npcm_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    logic [npcm_pkg::CFG_DATA_WIDTH-1:0] r_subset_indices;
    logic [npcm_pkg::COUNT_WIDTH-1:0]    r_subset_count;
    logic [npcm_pkg::COUNT_WIDTH-1:0]    count_sat;

    logic                                r_s1_valid;
    logic [npcm_pkg::PIXEL_WIDTH-1:0]    r_pixel;
    logic                                r_s2_valid;
    npcm_pkg::t_cand [npcm_pkg::LIST_LEN-1:0] r_cands;
    npcm_pkg::t_cand [npcm_pkg::LIST_LEN-1:0] n_cands;
    logic                                r_out_valid;
    logic [npcm_pkg::POS_WIDTH-1:0]      r_pos;
    npcm_pkg::t_cand                     best;

    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic in_accept;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subset_indices <= npcm_pkg::SUBSET_INDICES_RESET;
            r_subset_count   <= npcm_pkg::SUBSET_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == npcm_pkg::REG_SUBSET_INDICES) begin
                r_subset_indices <= i_cfg_data;
            end else if (i_cfg_index == npcm_pkg::REG_SUBSET_COUNT) begin
                r_subset_count <= i_cfg_data[npcm_pkg::COUNT_WIDTH-1:0];
            end
        end
    end

    assign count_sat = (r_subset_count > npcm_pkg::COUNT_WIDTH'(npcm_pkg::LIST_LEN))
                     ? npcm_pkg::COUNT_WIDTH'(npcm_pkg::LIST_LEN) : r_subset_count;

    // pipeline flow
    assign s3_load         = !r_out_valid || i_m_axis_tready;
    assign s2_load         = !r_s2_valid || s3_load;
    assign s1_load         = !r_s1_valid || s2_load;
    assign o_s_axis_tready = s1_load;
    assign in_accept       = i_s_axis_tvalid && s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_load) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // distance lanes
    for (genvar k = 0; k < npcm_pkg::LIST_LEN; k++) begin : g_lane
        npcm_lane u_lane (
            .i_pixel     (r_pixel),
            .i_pal_index (r_subset_indices[npcm_pkg::INDEX_WIDTH*k +: npcm_pkg::INDEX_WIDTH]),
            .i_active    (npcm_pkg::COUNT_WIDTH'(k) < count_sat),
            .o_dist      (n_cands[k].score)
        );
        assign n_cands[k].pos = npcm_pkg::POS_WIDTH'(k);
    end

    npcm_argmin u_argmin (
        .i_cands (r_cands),
        .o_best  (best)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pixel <= i_s_axis_tdata;
        end
        if (s2_load && r_s1_valid) begin
            r_cands <= n_cands;
        end
        if (s3_load && r_s2_valid) begin
            r_pos <= best.pos;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = npcm_pkg::OUT_TDATA_WIDTH'(r_pos);

    `NPCM_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, in_accept, r_s1_valid)
    `NPCM_ASSERT_NEXT(a_s2_held, i_clk, i_rst_n, r_s2_valid && !s3_load, r_s2_valid)
    `NPCM_ASSERT_SAME(a_best_le_first, i_clk, i_rst_n, r_s2_valid, best.score <= r_cands[0].score)

endmodule

`default_nettype wire

[tb/sv/tb_nearest_palette_color_match.sv]
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_match
// Streams pixels through the colour matcher and checks every list position.
// ----------------------------------------------------------------------------
// A directed table covers the palette extremes, exact palette hits, an empty
// search, count saturation, ties and an unused register index. Random phases
// follow, each with its own subset list and count. Pixels are either fully
// random or close to a palette colour, so near ties are common. Every result
// is compared with a position given in the table or worked out here from a
// private copy of the palette and of the two registers. Both stream sides idle
// at random, one phase runs with no idling, and one phase holds the output off
// long enough to back the pipeline up into the input.
`default_nettype none

module tb_nearest_palette_color_match;

    localparam int unsigned PHASE_ITEMS = 170;
    localparam int unsigned NUM_PHASES  = 9;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam int          NO_WANT     = -1;

    localparam logic [npcm_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 8'd2;

    // 0xRRGGBB
    localparam logic [23:0] PALETTE_RGB [16] = '{
        24'h000000, 24'hffffff, 24'h894036, 24'h7abfc7,
        24'h8a46ae, 24'h68a941, 24'h3e31a2, 24'hd0dc71,
        24'h905f25, 24'h5c4700, 24'hbb776d, 24'h555555,
        24'h808080, 24'hacea88, 24'h7c70da, 24'hababab
    };

    typedef enum bit {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                            kind;
        logic [npcm_pkg::CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [npcm_pkg::CFG_DATA_WIDTH-1:0]  value;
        logic [npcm_pkg::PIXEL_WIDTH-1:0]     pixel;
        int                                   want_pos;
    } t_step;

    localparam int unsigned NUM_DIRECTED = 30;

    localparam t_step DIRECTED_STEPS [NUM_DIRECTED] = '{
        '{ROW_PIXEL, '0, '0, 24'h000000, 0},
        '{ROW_PIXEL, '0, '0, 24'hffffff, 1},
        '{ROW_PIXEL, '0, '0, 24'h364089, 2},
        '{ROW_PIXEL, '0, '0, 24'hababab, 15},
        '{ROW_PIXEL, '0, '0, 24'h555555, 11},
        '{ROW_PIXEL, '0, '0, 24'hff0000, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'h00ff00, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'h0000ff, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'h123456, NO_WANT},
        // empty search
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_COUNT, 64'd0, '0, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'habcdef, 0},
        '{ROW_PIXEL, '0, '0, 24'hffffff, 0},
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_COUNT, 64'd1, '0, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'hffffff, 0},
        // count above list length, upper data bits set
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_COUNT, 64'hffff_ffff_ffff_ffff, '0, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'hffffff, 1},
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_COUNT, 64'd17, '0, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'h000000, 0},
        '{ROW_PIXEL, '0, '0, 24'h7f7f7f, NO_WANT},
        // every position the same colour, lowest position wins the tie
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_INDICES, 64'hffff_ffff_ffff_ffff, '0, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'hffffff, 0},
        '{ROW_PIXEL, '0, '0, 24'h000000, 0},
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_INDICES, 64'h0123_4567_89ab_cdef, '0, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'h000000, 15},
        '{ROW_PIXEL, '0, '0, 24'hffffff, 14},
        '{ROW_WRITE, REG_UNUSED, 64'd0, '0, NO_WANT},
        '{ROW_PIXEL, '0, '0, 24'h000000, 15},
        '{ROW_PIXEL, '0, '0, 24'hda707c, 1},
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_INDICES, npcm_pkg::SUBSET_INDICES_RESET, '0,
          NO_WANT},
        '{ROW_WRITE, npcm_pkg::REG_SUBSET_COUNT, 64'd16, '0, NO_WANT}
    };

    logic                                 clk;
    logic                                 rst_n;
    logic                                 px_tvalid;
    logic                                 px_tready;
    logic [npcm_pkg::PIXEL_WIDTH-1:0]     px_tdata;
    logic                                 pos_tvalid;
    logic                                 pos_tready;
    logic [npcm_pkg::OUT_TDATA_WIDTH-1:0] pos_tdata;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [npcm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [npcm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    // shadow of the two registers
    logic [npcm_pkg::CFG_DATA_WIDTH-1:0]  list_indices;
    logic [npcm_pkg::COUNT_WIDTH-1:0]     list_count;

    logic [npcm_pkg::POS_WIDTH-1:0]       expected_positions [$];
    int unsigned                          mismatches;
    bit                                   gaps_on;
    bit                                   stalls_on;
    int unsigned                          hold_request;

    nearest_palette_color_match u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (px_tvalid),
        .o_s_axis_tready (px_tready),
        .i_s_axis_tdata  (px_tdata),
        .o_m_axis_tvalid (pos_tvalid),
        .i_m_axis_tready (pos_tready),
        .o_m_axis_tdata  (pos_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int unsigned chan_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic logic [npcm_pkg::POS_WIDTH-1:0] closest_position(
        input logic [npcm_pkg::PIXEL_WIDTH-1:0] px
    );
        int unsigned                      searched;
        int unsigned                      best;
        int unsigned                      score;
        logic [npcm_pkg::INDEX_WIDTH-1:0] idx;
        logic [23:0]                      col;
        logic [npcm_pkg::POS_WIDTH-1:0]   pos;
        searched = (list_count > 5'd16) ? 16 : int'(list_count);
        best     = 256;
        pos      = '0;
        for (int k = 0; k < searched; k++) begin
            idx = list_indices[4*k +: 4];
            if (idx >= npcm_pkg::PALETTE_SIZE) begin
                idx = npcm_pkg::INDEX_WIDTH'(npcm_pkg::PALETTE_SIZE - 1);
            end
            col   = PALETTE_RGB[idx];
            score = (chan_gap(col[23:16], px[7:0]) + chan_gap(col[15:8], px[15:8])
                     + chan_gap(col[7:0], px[23:16])) / 3;
            if (score < best) begin
                best = score;
                pos  = npcm_pkg::POS_WIDTH'(k);
            end
        end
        return pos;
    endfunction

    function automatic logic [7:0] byte_near(input logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(12)) - 6;
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return 8'(v);
    endfunction

    // half uniform, half close to a palette colour
    function automatic logic [npcm_pkg::PIXEL_WIDTH-1:0] random_pixel();
        logic [23:0] col;
        if ($urandom_range(1) == 0) begin
            return npcm_pkg::PIXEL_WIDTH'($urandom);
        end
        col = PALETTE_RGB[$urandom_range(15)];
        return {byte_near(col[7:0]), byte_near(col[15:8]), byte_near(col[23:16])};
    endfunction

    task automatic offer_pixel(input logic [npcm_pkg::PIXEL_WIDTH-1:0] px, input int want_pos);
        while (gaps_on && $urandom_range(99) < 27) begin
            @(negedge clk);
            px_tvalid <= 1'b0;
        end
        @(negedge clk);
        px_tvalid <= 1'b1;
        px_tdata  <= px;
        do @(posedge clk); while (!px_tready);
        expected_positions.push_back((want_pos == NO_WANT) ? closest_position(px)
                                                           : npcm_pkg::POS_WIDTH'(want_pos));
    endtask

    // stop offering and let every item in flight come out
    task automatic settle();
        @(negedge clk);
        px_tvalid <= 1'b0;
        while (expected_positions.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [npcm_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [npcm_pkg::CFG_DATA_WIDTH-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == npcm_pkg::REG_SUBSET_INDICES) begin
            list_indices = val;
        end else if (idx == npcm_pkg::REG_SUBSET_COUNT) begin
            list_count = val[npcm_pkg::COUNT_WIDTH-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // output side ready, with random stalls and an occasional long hold-off
    initial begin
        int unsigned hold_left;
        hold_left  = 0;
        pos_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                pos_tready <= 1'b0;
                hold_left--;
            end else if (stalls_on && $urandom_range(99) < 27) begin
                pos_tready <= 1'b0;
            end else begin
                pos_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        logic [npcm_pkg::POS_WIDTH-1:0] want;
        if (rst_n && pos_tvalid && pos_tready) begin
            if (expected_positions.size() == 0) begin
                report_mismatch($sformatf("position %0d with no pixel pending", pos_tdata));
            end else begin
                want = expected_positions.pop_front();
                if (pos_tdata !== {{(npcm_pkg::OUT_TDATA_WIDTH-npcm_pkg::POS_WIDTH){1'b0}},
                                   want}) begin
                    report_mismatch($sformatf("position %0h, expected %0d", pos_tdata, want));
                end
            end
        end
    end

    initial begin
        logic [3:0]                          few_idx [5];
        logic [npcm_pkg::CFG_DATA_WIDTH-1:0] new_indices;
        logic [npcm_pkg::CFG_DATA_WIDTH-1:0] new_count;
        t_step                               row;

        few_idx      = '{4'd0, 4'd1, 4'd11, 4'd12, 4'd15};
        mismatches   = 0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        hold_request = 0;
        rst_n        = 1'b0;
        px_tvalid    = 1'b0;
        px_tdata     = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        list_indices = npcm_pkg::SUBSET_INDICES_RESET;
        list_count   = npcm_pkg::SUBSET_COUNT_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED_STEPS[i];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_reg(row.reg_idx, row.value);
            end else begin
                offer_pixel(row.pixel, row.want_pos);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            new_indices = {$urandom, $urandom};
            new_count   = {$urandom, $urandom};
            case (phase)
                0: begin
                    new_indices = npcm_pkg::SUBSET_INDICES_RESET;
                    new_count   = 64'd16;
                end
                1: new_count = 64'd16;
                2: new_count = 64'($urandom_range(1, 16));
                3: begin
                    new_indices = 64'hffff_ffff_ffff_ffff;
                    new_count[npcm_pkg::COUNT_WIDTH-1:0] = 5'd31;
                end
                4: new_count = 64'd0;
                5: new_count[npcm_pkg::COUNT_WIDTH-1:0] = 5'($urandom_range(17, 31));
                6: new_count = 64'd1;
                7: begin
                    // repeated colours force ties
                    for (int k = 0; k < 16; k++) begin
                        new_indices[4*k +: 4] = few_idx[$urandom_range(4)];
                    end
                    new_count = 64'd16;
                end
                default: new_count = 64'($urandom_range(31));
            endcase
            settle();
            write_reg(npcm_pkg::REG_SUBSET_INDICES, new_indices);
            write_reg(npcm_pkg::REG_SUBSET_COUNT, new_count);
            gaps_on   = (phase != 2);
            stalls_on = (phase != 2);
            if (phase == 1) begin
                hold_request = HOLD_CYCLES;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer_pixel(random_pixel(), NO_WANT);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/npcm_pkg.sv
rtl/npcm_lane.sv
rtl/npcm_argmin.sv
rtl/nearest_palette_color_match.sv
tb/sv/tb_nearest_palette_color_match.sv
